>>> sv/lfg_pkg.sv
// lfg_pkg: shared types, codes and constants of the linear fade gate
// no dependencies; imported by every module of the block
package lfg_pkg;

    localparam int SAMPLE_BITS        = 16;
    localparam int GAIN_BITS          = 15;
    localparam int COUNT_BITS_DEFAULT = 16;
    localparam int LENGTH_BITS        = 16;

    localparam logic [LENGTH_BITS-1:0] FADE_LENGTH_RESET = 16'd128;
    localparam logic signed [SAMPLE_BITS-1:0] OUT_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_BITS-1:0] OUT_MIN = 16'sh8000;

    // item mode codes
    localparam logic [1:0] MODE_SAMPLE   = 2'd0;
    localparam logic [1:0] MODE_FADE_IN  = 2'd1;
    localparam logic [1:0] MODE_FADE_OUT = 2'd2;

    // result status codes
    localparam logic [1:0] STATUS_NONE     = 2'd0;
    localparam logic [1:0] STATUS_OUT_DONE = 2'd1;
    localparam logic [1:0] STATUS_IN_DONE  = 2'd2;

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_IN   = 2'd1,
        DIR_OUT  = 2'd2
    } fade_dir_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_MUL,
        ST_DONE
    } lfg_state_t;

    typedef struct packed {
        logic [1:0]                    mode;
        logic signed [SAMPLE_BITS-1:0] sample_in;
        logic                          last_in_frame;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_out;
        logic [1:0]                    fade_status;
    } out_item_t;

endpackage

>>> sv/lfg_div.sv
// lfg_div: bit-serial restoring divider for the fade gain, floor(num*32767/t)
// one quotient bit per cycle; uses lfg_pkg
module lfg_div
    import lfg_pkg::*;
#(
    parameter int CountBits = COUNT_BITS_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [CountBits-1:0] num,
    input  logic [CountBits-1:0] divisor,
    output logic                 done,
    output logic [GAIN_BITS-1:0] quot
);

    localparam int ProdW = CountBits + GAIN_BITS;
    localparam int CntW  = $clog2(GAIN_BITS);

    logic [CountBits-1:0] rem_reg, rem_next;
    logic [CountBits-1:0] dvs_reg, dvs_next;
    logic [GAIN_BITS-1:0] lo_reg, lo_next;
    logic [CntW-1:0]      cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [ProdW-1:0]     prod;
    logic [CountBits:0]   trial;
    logic [CountBits:0]   diff;

    always_comb
    begin
        // num * 32767 as (num << 15) - num
        prod      = {num, GAIN_BITS'(0)} - ProdW'(num);
        trial     = {rem_reg, lo_reg[GAIN_BITS-1]};
        diff      = trial - {1'b0, dvs_reg};
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        lo_next   = lo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = prod[ProdW-1:GAIN_BITS];
            lo_next   = prod[GAIN_BITS-1:0];
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // no borrow means trial >= divisor
            rem_next = diff[CountBits] ? trial[CountBits-1:0] : diff[CountBits-1:0];
            lo_next  = {lo_reg[GAIN_BITS-2:0], ~diff[CountBits]};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CntW'(GAIN_BITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        lo_reg  <= lo_next;
    end

    assign done = done_reg;
    assign quot = lo_reg;

endmodule

>>> sv/lfg_mul.sv
// lfg_mul: bit-serial shift-add multiplier, sample times q15 gain, floor >> 15
// and saturation to 16 bits; uses lfg_pkg
module lfg_mul
    import lfg_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic [GAIN_BITS-1:0]          gain,
    output logic                          done,
    output logic signed [SAMPLE_BITS-1:0] product
);

    localparam int AccW = SAMPLE_BITS + 2;
    localparam int CntW = $clog2(GAIN_BITS);
    localparam logic signed [AccW-1:0] SatHi = AccW'(OUT_MAX);
    localparam logic signed [AccW-1:0] SatLo = AccW'(OUT_MIN);

    logic signed [AccW-1:0]        hi_reg, hi_next;
    logic [GAIN_BITS-1:0]          lo_reg, lo_next;
    logic signed [SAMPLE_BITS-1:0] s_reg, s_next;
    logic [CntW-1:0]               cnt_reg, cnt_next;
    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic signed [AccW-1:0]        addend;
    logic signed [AccW-1:0]        sum;

    always_comb
    begin
        addend    = lo_reg[0] ? AccW'(s_reg) : SatHi ^ SatHi;
        sum       = hi_reg + addend;
        hi_next   = hi_reg;
        lo_next   = lo_reg;
        s_next    = s_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            hi_next   = '0;
            lo_next   = gain;
            s_next    = sample;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // low product bit drops off, which gives the floor shift
            hi_next  = sum >>> 1;
            lo_next  = {1'b0, lo_reg[GAIN_BITS-1:1]};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CntW'(GAIN_BITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        if (hi_reg > SatHi)
            product = OUT_MAX;
        else if (hi_reg < SatLo)
            product = OUT_MIN;
        else
            product = hi_reg[SAMPLE_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hi_reg <= hi_next;
        lo_reg <= lo_next;
        s_reg  <= s_next;
    end

    assign done = done_reg;

endmodule

>>> sv/linear_fade_gate_q15.sv
// linear_fade_gate_q15: top level of the pop-suppression fade gate
// uses lfg_pkg, lfg_div and lfg_mul
//
// Fade gate for 16-bit PCM. A fade-in or fade-out command (no result) arms a
// linear q15 gain ramp of fade_length samples (0 acts as 1); each following
// audio sample during the ramp is scaled by floor(k*32767/T) or
// floor((T-k)*32767/T), shifted right by 15 with floor and saturated, and the
// last ramp sample carries fade_status. After a fade out that ends before
// the frame end, the rest of the frame is zero. Other samples pass through.
// Sequencing: a sample inside a fade occupies the core from its transfer to
// the next possible input transfer, through the 15-step serial divider for
// the gain and then the 15-step serial multiplier; a passed-through or
// zeroed sample goes straight to the result stage; a command leaves it idle.
// The result sits in an output register, so a stalled result does not hold
// off the next input transfer until the core needs that register again.
// fade_length may be written any time the gate is idle.
module linear_fade_gate_q15
    import lfg_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // input items
    input  logic                   item_valid,
    output logic                   item_stall,
    input  in_item_t               item,
    // results
    output logic                   result_valid,
    input  logic                   result_stall,
    output out_item_t              result,
    // fade_length register writes
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [LENGTH_BITS-1:0] cfg_data
);

    localparam int CB = COUNT_BITS;

    // control state
    lfg_state_t             state_reg, state_next;
    fade_dir_t              fade_dir_reg, fade_dir_next;
    logic [CB-1:0]          remain_reg, remain_next;
    logic                   zero_rest_reg, zero_rest_next;
    logic [LENGTH_BITS-1:0] fade_length_reg, fade_length_next;
    logic                   result_valid_reg, result_valid_next;

    // payload held for the item in flight
    logic [CB-1:0]                 num_reg, num_next;
    logic [CB-1:0]                 t_reg, t_next;
    logic signed [SAMPLE_BITS-1:0] sample_reg, sample_next;
    logic [1:0]                    status_reg, status_next;
    logic signed [SAMPLE_BITS-1:0] res_hold_reg, res_hold_next;
    out_item_t                     result_reg, result_next;

    // ramp step arithmetic
    logic [CB-1:0] t_raw;
    logic [CB-1:0] t_eff;
    logic [CB-1:0] r_lim;
    logic [CB-1:0] r_eff;
    logic [CB-1:0] r_dec;
    logic          accept;
    logic          fade_active;

    // datapath handshakes
    logic                          div_start;
    logic                          div_done;
    logic [GAIN_BITS-1:0]          div_quot;
    logic                          mul_start;
    logic                          mul_done;
    logic signed [SAMPLE_BITS-1:0] mul_product;

    lfg_div #(
        .CountBits (CB)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .num     (num_reg),
        .divisor (t_reg),
        .done    (div_done),
        .quot    (div_quot)
    );

    lfg_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .sample  (sample_reg),
        .gain    (div_quot),
        .done    (mul_done),
        .product (mul_product)
    );

    // effective length and clamped step count, live from the register
    always_comb
    begin
        t_raw = CB'(fade_length_reg);
        t_eff = (t_raw == '0) ? CB'(1) : t_raw;
        r_lim = (remain_reg > t_eff) ? t_eff : remain_reg;
        r_eff = (r_lim == '0) ? CB'(1) : r_lim;
        r_dec = r_eff - CB'(1);
    end

    assign item_stall  = (state_reg != ST_IDLE);
    assign accept      = item_valid && !item_stall;
    assign fade_active = (fade_dir_reg != DIR_NONE);

    always_comb
    begin
        state_next        = state_reg;
        fade_dir_next     = fade_dir_reg;
        remain_next       = remain_reg;
        zero_rest_next    = zero_rest_reg;
        fade_length_next  = fade_length_reg;
        result_valid_next = result_valid_reg;
        num_next          = num_reg;
        t_next            = t_reg;
        sample_next       = sample_reg;
        status_next       = status_reg;
        res_hold_next     = res_hold_reg;
        result_next       = result_reg;
        div_start         = 1'b0;
        mul_start         = 1'b0;

        if (cfg_valid)
            fade_length_next = cfg_data;

        // result leaves on a transfer
        if (result_valid_reg && !result_stall)
            result_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (item.mode)
                        MODE_FADE_IN, MODE_FADE_OUT:
                        begin
                            // a new command replaces any fade or zeroing
                            fade_dir_next  = (item.mode == MODE_FADE_IN) ? DIR_IN : DIR_OUT;
                            remain_next    = t_eff;
                            zero_rest_next = 1'b0;
                        end
                        MODE_SAMPLE:
                        begin
                            sample_next = item.sample_in;
                            if (fade_active)
                            begin
                                remain_next = r_dec;
                                t_next      = t_eff;
                                // fade in uses k = t - r + 1, fade out t - k = r - 1
                                num_next    = (fade_dir_reg == DIR_IN) ? (t_eff - r_dec) : r_dec;
                                status_next = STATUS_NONE;
                                if (r_dec == '0)
                                begin
                                    fade_dir_next = DIR_NONE;
                                    if (fade_dir_reg == DIR_IN)
                                        status_next = STATUS_IN_DONE;
                                    else
                                    begin
                                        status_next = STATUS_OUT_DONE;
                                        if (!item.last_in_frame)
                                            zero_rest_next = 1'b1;
                                    end
                                end
                                state_next = ST_PREP;
                            end
                            else
                            begin
                                res_hold_next = zero_rest_reg ? '0 : item.sample_in;
                                status_next   = STATUS_NONE;
                                state_next    = ST_DONE;
                            end
                            if (item.last_in_frame)
                                zero_rest_next = 1'b0;
                        end
                        default:
                        begin
                            // unused mode, dropped
                        end
                    endcase
                end
            end
            ST_PREP:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    mul_start  = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                if (mul_done)
                begin
                    res_hold_next = mul_product;
                    state_next    = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // wait for a free output register
                if (!result_valid_reg || !result_stall)
                begin
                    result_next.sample_out  = res_hold_reg;
                    result_next.fade_status = status_reg;
                    result_valid_next       = 1'b1;
                    state_next              = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            fade_dir_reg     <= DIR_NONE;
            remain_reg       <= '0;
            zero_rest_reg    <= 1'b0;
            fade_length_reg  <= FADE_LENGTH_RESET;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            fade_dir_reg     <= fade_dir_next;
            remain_reg       <= remain_next;
            zero_rest_reg    <= zero_rest_next;
            fade_length_reg  <= fade_length_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg      <= num_next;
        t_reg        <= t_next;
        sample_reg   <= sample_next;
        status_reg   <= status_next;
        res_hold_reg <= res_hold_next;
        result_reg   <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign cfg_ready    = 1'b1;

    // divider finishes only while the sequencer waits on it
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider done outside divide phase");

    // multiplier finishes only while the sequencer waits on it
    assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> (state_reg == ST_MUL))
        else $error("multiplier done outside multiply phase");

    // a fade command arms a ramp and cancels pending zeroing
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (item.mode == MODE_FADE_IN || item.mode == MODE_FADE_OUT))
        |=> (!zero_rest_reg && fade_dir_reg != DIR_NONE))
        else $error("fade command did not arm the ramp");

endmodule
